FILE: rtl/saw_pkg.sv
// Shared types and constants for the stop-and-wait sender.
// Used by saw_front, saw_fifo, saw_back and the top level; no dependencies.
`timescale 1ns / 1ps

package saw_pkg;

    localparam int COUNT_W = 6;
    localparam int SEQ_W   = 16;

    localparam logic [15:0] TIMEOUT_RESET = 16'd2;

    // Input item codes carried on tuser.
    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_ACK  = 2'd1;
    localparam logic [1:0] FUNC_TICK = 2'd2;

    // Result kinds.
    localparam logic [2:0] KIND_SEQ      = 3'd0;
    localparam logic [2:0] KIND_LEN      = 3'd1;
    localparam logic [2:0] KIND_DATA     = 3'd2;
    localparam logic [2:0] KIND_SUM      = 3'd3;
    localparam logic [2:0] KIND_ACK_OK   = 3'd4;
    localparam logic [2:0] KIND_ACK_IGN  = 3'd5;
    localparam logic [2:0] KIND_REJECTED = 3'd6;

    typedef enum logic {
        CMD_STATUS,
        CMD_FRAME
    } t_cmd_op;

    // One request from the front to the back. For a frame, value is the
    // sequence number; for a status, value is the reported number.
    typedef struct packed {
        t_cmd_op              op;
        logic [2:0]           kind;
        logic [15:0]          value;
        logic [COUNT_W-1:0]   count;
        logic [15:0]          sum;
        logic                 resend;
    } t_cmd;

    typedef struct packed {
        logic                 en;
        logic [COUNT_W-1:0]   addr;
        logic [7:0]           data;
    } t_wr;

endpackage

FILE: rtl/stop_and_wait_arq_sender_core.sv
// Stop-and-wait sender. Requests that give results go through the request
// queue and then the output register; a frame (PAYLOAD_BYTES + 3 results)
// leaves at one result per cycle while i_m_tready is high. Loads that fill
// the buffer wait while a frame is being read out, and all requests wait
// while the queue is full. Reset (i_rst_n low, synchronous) empties the
// queue, clears the control state and sets the timeout to two ticks.
`timescale 1ns / 1ps

module stop_and_wait_arq_sender_core #(
    parameter int PAYLOAD_BYTES = 46
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,   // timeout_ticks
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,     // [7:0] data_byte, [23:8] ack_number
    input  logic        i_s_tlast,     // last_byte
    input  logic [1:0]  i_s_tuser,     // [1:0] func
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,     // [15:0] out_value
    output logic        o_m_tlast,     // out_last
    output logic [3:0]  o_m_tuser      // [2:0] out_kind, [3] is_resend
);
    import saw_pkg::*;

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    logic back_idle;
    t_cmd push_cmd;
    t_cmd head_cmd;
    t_wr  buf_wr;

    saw_front #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .i_s_tuser   (i_s_tuser),
        .i_q_full    (q_full),
        .i_q_empty   (q_empty),
        .i_back_idle (back_idle),
        .o_push      (q_push),
        .o_cmd       (push_cmd),
        .o_wr        (buf_wr)
    );

    saw_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .i_pop   (q_pop),
        .o_cmd   (head_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    saw_back #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (buf_wr),
        .i_q_empty  (q_empty),
        .i_cmd      (head_cmd),
        .o_pop      (q_pop),
        .o_idle     (back_idle),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

FILE: rtl/saw_fifo.sv
// Two-entry request queue between the front and back parts of the sender.
// Depends on saw_pkg for the request type.
`timescale 1ns / 1ps

module saw_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  saw_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output saw_pkg::t_cmd o_cmd,
    output logic          o_full,
    output logic          o_empty
);
    import saw_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_fill;

    assign o_cmd   = r_mem[r_rptr];
    assign o_full  = (r_fill == 2'd2);
    assign o_empty = (r_fill == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (i_push) begin
                r_mem[r_wptr] <= i_cmd;
                r_wptr        <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

FILE: rtl/saw_front.sv
// Front part of the sender: accepts input items, keeps the protocol state
// (sequence, count, checksum, wait flag, tick counter) and queues requests.
// Depends on saw_pkg.
`timescale 1ns / 1ps

module saw_front #(
    parameter int PAYLOAD_BYTES = 46
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [15:0]   i_cfg_wdata,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [23:0]   i_s_tdata,
    input  logic          i_s_tlast,
    input  logic [1:0]    i_s_tuser,
    input  logic          i_q_full,
    input  logic          i_q_empty,
    input  logic          i_back_idle,
    output logic          o_push,
    output saw_pkg::t_cmd o_cmd,
    output saw_pkg::t_wr  o_wr
);
    import saw_pkg::*;

    localparam logic [COUNT_W-1:0] FULL_CNT = COUNT_W'(PAYLOAD_BYTES);

    logic [15:0]        r_timeout;
    logic [15:0]        r_seq;
    logic [COUNT_W-1:0] r_cnt;
    logic [15:0]        r_sum;
    logic [15:0]        r_tick;
    logic               r_await;

    logic [15:0]        n_seq;
    logic [COUNT_W-1:0] n_cnt;
    logic [15:0]        n_sum;
    logic [15:0]        n_tick;
    logic               n_await;

    logic               w_accept;
    logic [7:0]         w_byte;
    logic [15:0]        w_ackn;
    logic [15:0]        w_limit;
    logic               w_fill_blocked;

    assign w_byte  = i_s_tdata[7:0];
    assign w_ackn  = i_s_tdata[23:8];
    assign w_limit = (r_timeout == 16'd0) ? 16'd1 : r_timeout;

    // A load that writes the buffer waits until any frame in flight has been
    // read out completely, since the back part reads the same buffer.
    assign w_fill_blocked = (i_s_tuser == FUNC_LOAD) && !r_await
                            && !(i_back_idle && i_q_empty);
    assign o_s_tready     = !i_q_full && !w_fill_blocked;
    assign w_accept       = i_s_tvalid && o_s_tready;

    always_comb begin
        n_seq   = r_seq;
        n_cnt   = r_cnt;
        n_sum   = r_sum;
        n_tick  = r_tick;
        n_await = r_await;
        o_push  = 1'b0;
        o_cmd   = '{op: CMD_STATUS, kind: KIND_ACK_IGN, value: w_ackn,
                    count: r_cnt, sum: r_sum, resend: 1'b0};
        o_wr    = '{en: 1'b0, addr: r_cnt, data: w_byte};
        if (w_accept) begin
            case (i_s_tuser)
                FUNC_LOAD: begin
                    if (r_await) begin
                        o_push      = 1'b1;
                        o_cmd.kind  = KIND_REJECTED;
                        o_cmd.value = {8'd0, w_byte};
                    end else begin
                        if (r_cnt < FULL_CNT) begin
                            o_wr.en = 1'b1;
                            n_cnt   = r_cnt + COUNT_W'(1);
                            n_sum   = r_sum + {8'd0, w_byte};
                        end
                        if (n_cnt >= FULL_CNT || i_s_tlast) begin
                            n_await     = 1'b1;
                            n_tick      = 16'd0;
                            o_push      = 1'b1;
                            o_cmd.op    = CMD_FRAME;
                            o_cmd.kind  = KIND_SEQ;
                            o_cmd.value = r_seq;
                            o_cmd.count = n_cnt;
                            o_cmd.sum   = n_sum;
                        end
                    end
                end
                FUNC_ACK: begin
                    o_push = 1'b1;
                    if (r_await && w_ackn == r_seq) begin
                        o_cmd.kind = KIND_ACK_OK;
                        n_seq      = r_seq + 16'd1;
                        n_await    = 1'b0;
                        n_tick     = 16'd0;
                        n_cnt      = '0;
                        n_sum      = 16'd0;
                    end
                end
                FUNC_TICK: begin
                    if (r_await) begin
                        if ({1'b0, r_tick} + 17'd1 >= {1'b0, w_limit}) begin
                            n_tick       = 16'd0;
                            o_push       = 1'b1;
                            o_cmd.op     = CMD_FRAME;
                            o_cmd.kind   = KIND_SEQ;
                            o_cmd.value  = r_seq;
                            o_cmd.resend = 1'b1;
                        end else begin
                            n_tick = r_tick + 16'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
            r_seq     <= 16'd0;
            r_cnt     <= '0;
            r_sum     <= 16'd0;
            r_tick    <= 16'd0;
            r_await   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            r_seq   <= n_seq;
            r_cnt   <= n_cnt;
            r_sum   <= n_sum;
            r_tick  <= n_tick;
            r_await <= n_await;
        end
    end

endmodule

FILE: rtl/saw_back.sv
// Back part of the sender: holds the payload buffer, turns queued requests
// into result items and drives the output register. Depends on saw_pkg.
`timescale 1ns / 1ps

module saw_back #(
    parameter int PAYLOAD_BYTES = 46
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  saw_pkg::t_wr  i_wr,
    input  logic          i_q_empty,
    input  saw_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_idle,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [15:0]   o_m_tdata,
    output logic          o_m_tlast,
    output logic [3:0]    o_m_tuser
);
    import saw_pkg::*;

    localparam int AW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam logic [COUNT_W-1:0] LAST_IDX = COUNT_W'(PAYLOAD_BYTES - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LEN,
        ST_DATA,
        ST_SUM
    } t_state;

    t_state             r_state;
    logic [7:0]         r_mem [PAYLOAD_BYTES];
    logic [7:0]         r_rd_data;
    logic [COUNT_W-1:0] r_idx;
    logic [COUNT_W-1:0] r_cnt;
    logic [15:0]        r_sum;
    logic               r_resend;

    logic               r_valid;
    logic [2:0]         r_kind;
    logic [15:0]        r_value;
    logic               r_last;
    logic               r_out_resend;

    logic [COUNT_W-1:0] n_idx;
    logic               w_load;

    assign w_load     = !r_valid || i_m_tready;
    assign o_pop      = w_load && (r_state == ST_IDLE) && !i_q_empty;
    assign o_idle     = (r_state == ST_IDLE);
    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_value;
    assign o_m_tlast  = r_last;
    assign o_m_tuser  = {r_out_resend, r_kind};

    // The buffer is read at the index the walk will hold next, so that the
    // registered byte lines up with the index when the result is loaded.
    // After the last slot the index returns to zero and stays in the buffer.
    always_comb begin
        n_idx = r_idx;
        if (w_load) begin
            unique case (r_state)
                ST_LEN:  n_idx = '0;
                ST_DATA: n_idx = (r_idx == LAST_IDX) ? '0 : r_idx + COUNT_W'(1);
                ST_IDLE,
                ST_SUM:  n_idx = r_idx;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr[AW-1:0]] <= i_wr.data;
        end
        r_rd_data <= r_mem[n_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (w_load) begin
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_q_empty) begin
                        r_valid <= 1'b1;
                        r_value <= i_cmd.value;
                        if (i_cmd.op == CMD_STATUS) begin
                            r_kind       <= i_cmd.kind;
                            r_last       <= 1'b1;
                            r_out_resend <= 1'b0;
                        end else begin
                            r_kind       <= KIND_SEQ;
                            r_last       <= 1'b0;
                            r_out_resend <= i_cmd.resend;
                            r_cnt        <= i_cmd.count;
                            r_sum        <= i_cmd.sum;
                            r_resend     <= i_cmd.resend;
                            r_state      <= ST_LEN;
                        end
                    end else begin
                        r_valid <= 1'b0;
                    end
                end
                ST_LEN: begin
                    r_valid      <= 1'b1;
                    r_kind       <= KIND_LEN;
                    r_value      <= {{(16 - COUNT_W){1'b0}}, r_cnt};
                    r_last       <= 1'b0;
                    r_out_resend <= r_resend;
                    r_idx        <= n_idx;
                    r_state      <= ST_DATA;
                end
                ST_DATA: begin
                    r_valid      <= 1'b1;
                    r_kind       <= KIND_DATA;
                    r_value      <= (r_idx < r_cnt) ? {8'd0, r_rd_data} : 16'd0;
                    r_last       <= 1'b0;
                    r_out_resend <= r_resend;
                    r_idx        <= n_idx;
                    if (r_idx == LAST_IDX) begin
                        r_state <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    r_valid      <= 1'b1;
                    r_kind       <= KIND_SUM;
                    r_value      <= r_sum;
                    r_last       <= 1'b1;
                    r_out_resend <= r_resend;
                    r_state      <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
